>>> design/cspbm_pkg.sv
package cspbm_pkg;

    // default depth of the slot chain
    localparam int MAX_SLOTS_DEF = 16;

    // field widths
    localparam int FUNC_W   = 3;
    localparam int BYTES_W  = 40;
    localparam int TICK_W   = 32;
    localparam int ID_W     = 32;
    localparam int TOTAL_W  = 44;
    localparam int EPOCH_W  = 64;
    localparam int EVICT_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 5;
    localparam int CFG_IDX_W = 1;

    // register reset values
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST  = 5'd4;
    localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST = 40'd67108864;
    localparam logic [ID_W-1:0]    FIRST_ID        = 32'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET = 1'b1;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_TAKE        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE_ID  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE_NEW = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TRIM        = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NEVER     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EVICTED   = 2'd3;

    // one resident checkpoint
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] size;
        logic [TICK_W-1:0]  tick;
    } slot_t;

    // command broadcast to every cell
    typedef struct packed {
        logic rot;
        logic load;
    } cell_cmd_t;

    // one request
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTES_W-1:0] bytes;
        logic [TICK_W-1:0]  tick;
        logic [ID_W-1:0]    want;
    } req_t;

    // one result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [TICK_W-1:0]   tick;
        logic [BYTES_W-1:0]  bytes;
        logic [EPOCH_W-1:0]  prior_epoch;
        logic [EPOCH_W-1:0]  later_epoch;
        logic [EVICT_W-1:0]  evictions;
    } res_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVICT  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

>>> design/checkpoint_slot_budget_manager_top.sv
// Checkpoint slot budget manager.
// Requests arrive on the s_axis channel (func in tuser, operands in tdata);
// each request gives exactly one result transaction on m_axis. Registers
// slot_limit (index 0) and byte_budget (index 1) are written through the
// cfg port; the user must write them only while the block is idle, which
// the block itself does not enforce. A slot_limit write of zero is dropped.
// Resident slots live in a row of MAX_SLOTS cells kept oldest first; every
// eviction and every search step rotates the whole row by one cell. A take
// or trim evicts the oldest slot, one per rotation, until the store is within
// its limits; a restore turns the row once fully past cell 0; a clear, a
// refused take, an empty restore of newest and unused codes go straight to
// the result. The result is registered: it passes from the ST_DONE state
// into the output register that drives m_axis.
// s_axis_tready is high only while no request is being worked on; a result
// waiting on a stalled m_axis does not block the next request, which then
// holds in its last cycle until the output register frees up.
// Reset clears the store, restarts ids at 1, zeroes the epoch and eviction
// counters and restores the register defaults; no clearing pass is needed.
module checkpoint_slot_budget_manager_top #(
    parameter int MAX_SLOTS = cspbm_pkg::MAX_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ckpt_bytes[39:0], sim_tick[71:40], want_id[103:72]
    input  logic [103:0]                        s_axis_tdata,
    // func[2:0]
    input  logic [cspbm_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], result_id[33:2], result_tick[65:34], result_bytes[105:66],
    // prior epoch[169:106], later epoch[233:170], eviction_total[265:234], zero
    output logic [271:0]                        m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [cspbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cspbm_pkg::BYTES_W-1:0]       cfg_wdata
);

    localparam int CNTW = $clog2(MAX_SLOTS + 1);

    cspbm_pkg::req_t      req;
    cspbm_pkg::res_t      res;
    cspbm_pkg::cell_cmd_t cmd;
    cspbm_pkg::slot_t     load_data;
    cspbm_pkg::slot_t     cell_q [MAX_SLOTS];
    logic [CNTW-1:0]      count;

    // unpack request
    assign req.func  = s_axis_tuser;
    assign req.bytes = s_axis_tdata[39:0];
    assign req.tick  = s_axis_tdata[71:40];
    assign req.want  = s_axis_tdata[103:72];

    cspbm_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .CNTW      (CNTW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req       (req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (cell_q[0]),
        .cmd       (cmd),
        .load_data (load_data),
        .count     (count)
    );

    // row of slot cells, each fed by its younger neighbor, last wraps to first
    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        cspbm_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .load_here (count == CNTW'(i)),
            .load_data (load_data),
            .nbr_in    (cell_q[(i + 1) % MAX_SLOTS]),
            .slot_q    (cell_q[i])
        );
    end

    // pack result
    assign m_axis_tdata = {6'd0, res.evictions, res.later_epoch, res.prior_epoch,
                           res.bytes, res.tick, res.id, res.status};

endmodule

>>> design/cspbm_cell.sv
module cspbm_cell (
    input  logic                 clk,
    input  cspbm_pkg::cell_cmd_t cmd,
    input  logic                 load_here,
    input  cspbm_pkg::slot_t     load_data,
    input  cspbm_pkg::slot_t     nbr_in,
    output cspbm_pkg::slot_t     slot_q
);

    cspbm_pkg::slot_t slot_reg;

    // take from the younger neighbor on rotate, or load a new slot here
    always_ff @(posedge clk)
    begin
        if (cmd.rot)
        begin
            slot_reg <= nbr_in;
        end
        else if (cmd.load && load_here)
        begin
            slot_reg <= load_data;
        end
    end

    assign slot_q = slot_reg;

endmodule

>>> design/cspbm_ctrl.sv
module cspbm_ctrl #(
    parameter int MAX_SLOTS = cspbm_pkg::MAX_SLOTS_DEF,
    parameter int CNTW      = $clog2(MAX_SLOTS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cspbm_pkg::req_t                     req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cspbm_pkg::res_t                     res,
    input  logic                                cfg_wr_en,
    input  logic [cspbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cspbm_pkg::BYTES_W-1:0]       cfg_wdata,
    input  cspbm_pkg::slot_t                    head,
    output cspbm_pkg::cell_cmd_t                cmd,
    output cspbm_pkg::slot_t                    load_data,
    output logic [CNTW-1:0]                     count
);

    localparam int KW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW = (CNTW > cspbm_pkg::LIMIT_W) ? CNTW : cspbm_pkg::LIMIT_W;
    localparam logic [KW-1:0]   LAST_STEP = KW'(MAX_SLOTS - 1);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(MAX_SLOTS);

    cspbm_pkg::state_t state_reg, state_next;
    cspbm_pkg::req_t   req_reg, req_next;
    logic [CNTW-1:0]                   count_reg, count_next;
    logic [cspbm_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [cspbm_pkg::ID_W-1:0]        next_id_reg, next_id_next;
    logic [cspbm_pkg::EVICT_W-1:0]     evict_reg, evict_next;
    logic [cspbm_pkg::EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [cspbm_pkg::LIMIT_W-1:0]     limit_reg;
    logic [cspbm_pkg::BYTES_W-1:0]     budget_reg;
    logic [KW-1:0]                     step_reg, step_next;
    logic                              found_reg, found_next;
    cspbm_pkg::slot_t                  hit_reg, hit_next;
    cspbm_pkg::res_t                   rs_reg, rs_next;
    logic                              out_valid_reg, out_valid_next;
    cspbm_pkg::res_t                   out_reg, out_next;

    logic [CNTW-1:0]                   lim_eff;
    logic [cspbm_pkg::TOTAL_W:0]       fit_sum;
    logic                              drop;
    logic [CNTW-1:0]                   step_ext;
    logic                              hit;
    logic                              found_now;
    cspbm_pkg::slot_t                  slot_now;
    logic                              issued;

    // effective slot limit, capped at chain depth
    assign lim_eff = (LW'(limit_reg) > LW'(MAX_SLOTS)) ? CNTW'(MAX_SLOTS)
                                                       : CNTW'(limit_reg);

    // oldest slot must go when full or over budget
    assign fit_sum = {1'b0, total_reg} + (cspbm_pkg::TOTAL_W + 1)'(req_reg.bytes);
    always_comb
    begin
        if (req_reg.func == cspbm_pkg::FUNC_TAKE)
        begin
            drop = (count_reg != '0) &&
                   ((count_reg >= lim_eff) ||
                    (fit_sum > (cspbm_pkg::TOTAL_W + 1)'(budget_reg)));
        end
        else
        begin
            drop = (count_reg > lim_eff);
        end
    end

    // search step: head cell holds slot number step_reg
    assign step_ext = CNTW'(step_reg);
    always_comb
    begin
        if (req_reg.func == cspbm_pkg::FUNC_RESTORE_ID)
        begin
            hit = !found_reg && (step_ext < count_reg) && (head.id == req_reg.want);
        end
        else
        begin
            hit = !found_reg && (step_ext < count_reg) &&
                  (step_ext == count_reg - CNTW'(1));
        end
    end
    assign found_now = found_reg || hit;
    assign slot_now  = hit ? head : hit_reg;
    assign issued    = (req_reg.want - 32'd1) < (next_id_reg - 32'd1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        next_id_next   = next_id_reg;
        evict_next     = evict_reg;
        epoch_next     = epoch_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        rs_next        = rs_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd            = '0;
        load_data      = '{id: next_id_reg, size: req_reg.bytes, tick: req_reg.tick};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cspbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req;
                    step_next  = '0;
                    found_next = 1'b0;
                    rs_next    = '0;
                    unique case (req.func)
                        cspbm_pkg::FUNC_TAKE:
                        begin
                            if (req.bytes > budget_reg)
                            begin
                                rs_next.status = cspbm_pkg::STATUS_TOO_LARGE;
                                rs_next.bytes  = req.bytes;
                                state_next     = cspbm_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = cspbm_pkg::ST_EVICT;
                            end
                        end
                        cspbm_pkg::FUNC_RESTORE_ID:
                        begin
                            state_next = cspbm_pkg::ST_SEARCH;
                        end
                        cspbm_pkg::FUNC_RESTORE_NEW:
                        begin
                            if (count_reg == '0)
                            begin
                                rs_next.status = cspbm_pkg::STATUS_NEVER;
                                state_next     = cspbm_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = cspbm_pkg::ST_SEARCH;
                            end
                        end
                        cspbm_pkg::FUNC_CLEAR:
                        begin
                            count_next   = '0;
                            total_next   = '0;
                            next_id_next = cspbm_pkg::FIRST_ID;
                            evict_next   = '0;
                            state_next   = cspbm_pkg::ST_DONE;
                        end
                        cspbm_pkg::FUNC_TRIM:
                        begin
                            state_next = cspbm_pkg::ST_EVICT;
                        end
                        default:
                        begin
                            state_next = cspbm_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            cspbm_pkg::ST_EVICT:
            begin
                if (drop)
                begin
                    cmd.rot    = 1'b1;
                    total_next = total_reg - cspbm_pkg::TOTAL_W'(head.size);
                    count_next = count_reg - CNTW'(1);
                    evict_next = evict_reg + 32'd1;
                end
                else
                begin
                    if (req_reg.func == cspbm_pkg::FUNC_TAKE)
                    begin
                        cmd.load       = 1'b1;
                        count_next     = count_reg + CNTW'(1);
                        total_next     = total_reg + cspbm_pkg::TOTAL_W'(req_reg.bytes);
                        rs_next.status = cspbm_pkg::STATUS_OK;
                        rs_next.id     = next_id_reg;
                        rs_next.tick   = req_reg.tick;
                        rs_next.bytes  = req_reg.bytes;
                        next_id_next   = next_id_reg + 32'd1;
                    end
                    state_next = cspbm_pkg::ST_DONE;
                end
            end

            cspbm_pkg::ST_SEARCH:
            begin
                // a full turn of the chain leaves the order as it was
                cmd.rot    = 1'b1;
                found_next = found_now;
                hit_next   = slot_now;
                step_next  = step_reg + KW'(1);
                if (step_reg == LAST_STEP)
                begin
                    if (found_now)
                    begin
                        rs_next.status      = cspbm_pkg::STATUS_OK;
                        rs_next.id          = slot_now.id;
                        rs_next.tick        = slot_now.tick;
                        rs_next.bytes       = slot_now.size;
                        rs_next.prior_epoch = epoch_reg;
                        rs_next.later_epoch = epoch_reg + 64'd1;
                        epoch_next          = epoch_reg + 64'd1;
                    end
                    else
                    begin
                        rs_next.status = issued ? cspbm_pkg::STATUS_EVICTED
                                                : cspbm_pkg::STATUS_NEVER;
                    end
                    state_next = cspbm_pkg::ST_DONE;
                end
            end

            cspbm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next           = rs_reg;
                    out_next.evictions = evict_reg;
                    out_valid_next     = 1'b1;
                    state_next         = cspbm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cspbm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cspbm_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            next_id_reg   <= cspbm_pkg::FIRST_ID;
            evict_reg     <= '0;
            epoch_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            next_id_reg   <= next_id_next;
            evict_reg     <= evict_next;
            epoch_reg     <= epoch_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= cspbm_pkg::SLOT_LIMIT_RST;
            budget_reg <= cspbm_pkg::BYTE_BUDGET_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cspbm_pkg::CFG_SLOT_LIMIT:
                begin
                    if (cfg_wdata[cspbm_pkg::LIMIT_W-1:0] != '0)
                    begin
                        limit_reg <= cfg_wdata[cspbm_pkg::LIMIT_W-1:0];
                    end
                end
                cspbm_pkg::CFG_BYTE_BUDGET:
                begin
                    budget_reg <= cfg_wdata;
                end
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        hit_reg <= hit_next;
        rs_reg  <= rs_next;
        out_reg <= out_next;
    end

    assign in_ready  = (state_reg == cspbm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign res       = out_reg;
    assign count     = count_reg;

    // never more resident slots than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("resident count exceeds chain depth");

    // an empty store holds no bytes
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("byte total nonzero with empty store");

    // a search always ends after a full turn of the chain
    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cspbm_pkg::ST_SEARCH && state_next != cspbm_pkg::ST_SEARCH)
        |-> (step_reg == LAST_STEP))
        else $error("search left before chain order restored");

    // epoch moves only at the end of a search
    a_epoch_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cspbm_pkg::ST_SEARCH) |=> (epoch_reg == $past(epoch_reg)))
        else $error("epoch changed outside a restore");

endmodule
